@@ rtl/core/d2d_pkg.sv @@
package d2d_pkg;

    localparam int EXP_W = 13;
    localparam int MAN_W = 53;
    localparam int PROD_W = 2 * MAN_W;
    localparam int POW_START = 256;
    localparam int POW_STEPS = 9;
    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [3:0] ROUND_UP = 4'd5;

    // unpacked binary64: value = man * 2^(exp - 52), man normalized
    typedef struct packed {
        logic signed [EXP_W-1:0] exp;
        logic [MAN_W-1:0]        man;
    } d2d_fp_t;

    typedef struct packed {
        logic    start;
        logic    mul;       // 1 = multiply a*b, 0 = normalize a
        d2d_fp_t a;
        d2d_fp_t b;
    } d2d_fpu_req_t;

    typedef struct packed {
        logic    done;
        d2d_fp_t val;
    } d2d_fpu_rsp_t;

    function automatic d2d_fp_t unpack_normal(input logic [63:0] bits);
        d2d_fp_t r;
        r.exp = $signed({2'b00, bits[62:52]}) - 13'sd1023;
        r.man = {1'b1, bits[51:0]};
        return r;
    endfunction

    // 1e-256 .. 1e-1, 1
    function automatic logic [63:0] neg_pow_bits(input logic [3:0] idx);
        logic [63:0] r;
        case (idx)
            4'd0:    r = 64'h0ac8062864ac6f43;
            4'd1:    r = 64'h255bba08cf8c979d;
            4'd2:    r = 64'h32a50ffd44f4a73d;
            4'd3:    r = 64'h3949f623d5a8a733;
            4'd4:    r = 64'h3c9cd2b297d889bc;
            4'd5:    r = 64'h3e45798ee2308c3a;
            4'd6:    r = 64'h3f1a36e2eb1c432d;
            4'd7:    r = 64'h3f847ae147ae147b;
            4'd8:    r = 64'h3fb999999999999a;
            default: r = 64'h3ff0000000000000;
        endcase
        return r;
    endfunction

    // 1e256 .. 1e1
    function automatic logic [63:0] pos_pow_bits(input logic [3:0] idx);
        logic [63:0] r;
        case (idx)
            4'd0:    r = 64'h75154fdd7f73bf3c;
            4'd1:    r = 64'h5a827748f9301d32;
            4'd2:    r = 64'h4d384f03e93ff9f5;
            4'd3:    r = 64'h4693b8b5b5056e17;
            4'd4:    r = 64'h4341c37937e08000;
            4'd5:    r = 64'h4197d78400000000;
            4'd6:    r = 64'h40c3880000000000;
            4'd7:    r = 64'h4059000000000000;
            default: r = 64'h4024000000000000;
        endcase
        return r;
    endfunction

    function automatic logic fp_lt(input d2d_fp_t a, input d2d_fp_t b);
        return (a.exp < b.exp) || ((a.exp == b.exp) && (a.man < b.man));
    endfunction

endpackage

@@ rtl/core/d2d_in_if.sv @@
interface d2d_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;
    logic        fixed_mode;
    logic [5:0]  digits_requested;

    modport source (output valid, output value_bits, output fixed_mode,
                    output digits_requested, input ready);
    modport sink (input valid, input value_bits, input fixed_mode,
                  input digits_requested, output ready);
endinterface

@@ rtl/core/d2d_out_if.sv @@
interface d2d_out_if;
    logic              valid;
    logic              ready;
    logic [3:0]        digit;
    logic              digit_valid;
    logic signed [9:0] point_position;
    logic              negative;
    logic              special;
    logic              last;

    modport source (output valid, output digit, output digit_valid,
                    output point_position, output negative, output special,
                    output last, input ready);
    modport sink (input valid, input digit, input digit_valid,
                  input point_position, input negative, input special,
                  input last, output ready);
endinterface

@@ rtl/core/d2d_fpu.sv @@
// Shared binary64 unit: multiply (RNE, four 27x27 partial products) or
// left-normalize a mantissa (16 or 1 bit per cycle).
module d2d_fpu
    import d2d_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  d2d_fpu_req_t req,
    output d2d_fpu_rsp_t rsp
);

    typedef enum logic [1:0] {F_IDLE, F_NORM, F_MUL, F_RND} fstate_t;

    localparam int LO_W = 27;

    fstate_t                 state_reg, state_next;
    logic signed [EXP_W-1:0] exp_reg, exp_next;
    logic [MAN_W-1:0]        man_reg, man_next;
    logic [MAN_W-1:0]        am_reg, am_next;
    logic [MAN_W-1:0]        bm_reg, bm_next;
    logic [PROD_W-1:0]       acc_reg, acc_next;
    logic [1:0]              step_reg, step_next;
    logic                    done_reg, done_next;

    logic [LO_W-1:0]         op_a, op_b;
    logic [2*LO_W-1:0]       pp;
    logic [6:0]              pp_sh;
    logic                    hi;
    logic [MAN_W-1:0]        rmant;
    logic                    guard, sticky, inc;
    logic [MAN_W:0]          rsum;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                op_a = am_reg[LO_W-1:0];
                op_b = bm_reg[LO_W-1:0];
                pp_sh = 7'd0;
            end
            2'd1:
            begin
                op_a = am_reg[LO_W-1:0];
                op_b = {1'b0, bm_reg[MAN_W-1:LO_W]};
                pp_sh = 7'(LO_W);
            end
            2'd2:
            begin
                op_a = {1'b0, am_reg[MAN_W-1:LO_W]};
                op_b = bm_reg[LO_W-1:0];
                pp_sh = 7'(LO_W);
            end
            default:
            begin
                op_a = {1'b0, am_reg[MAN_W-1:LO_W]};
                op_b = {1'b0, bm_reg[MAN_W-1:LO_W]};
                pp_sh = 7'(2 * LO_W);
            end
        endcase
        pp = op_a * op_b;

        hi     = acc_reg[PROD_W-1];
        rmant  = hi ? acc_reg[PROD_W-1:MAN_W] : acc_reg[PROD_W-2:MAN_W-1];
        guard  = hi ? acc_reg[MAN_W-1] : acc_reg[MAN_W-2];
        sticky = hi ? (|acc_reg[MAN_W-2:0]) : (|acc_reg[MAN_W-3:0]);
        inc    = guard & (sticky | rmant[0]);
        rsum   = {1'b0, rmant} + {{MAN_W{1'b0}}, inc};
    end

    always_comb
    begin
        state_next = state_reg;
        exp_next   = exp_reg;
        man_next   = man_reg;
        am_next    = am_reg;
        bm_next    = bm_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    if (req.mul)
                    begin
                        am_next    = req.a.man;
                        bm_next    = req.b.man;
                        exp_next   = req.a.exp + req.b.exp;
                        acc_next   = '0;
                        step_next  = 2'd0;
                        state_next = F_MUL;
                    end
                    else
                    begin
                        exp_next   = req.a.exp;
                        man_next   = req.a.man;
                        state_next = F_NORM;
                    end
                end
            end
            F_NORM:
            begin
                if (man_reg[MAN_W-1])
                begin
                    done_next  = 1'b1;
                    state_next = F_IDLE;
                end
                else if (man_reg[MAN_W-1:MAN_W-16] == '0)
                begin
                    man_next = man_reg << 16;
                    exp_next = exp_reg - EXP_W'(16);
                end
                else
                begin
                    man_next = man_reg << 1;
                    exp_next = exp_reg - EXP_W'(1);
                end
            end
            F_MUL:
            begin
                acc_next  = acc_reg + (PROD_W'(pp) << pp_sh);
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                    state_next = F_RND;
            end
            default:
            begin
                if (rsum[MAN_W])
                begin
                    man_next = rsum[MAN_W:1];
                    exp_next = exp_reg + EXP_W'(hi) + EXP_W'(1);
                end
                else
                begin
                    man_next = rsum[MAN_W-1:0];
                    exp_next = exp_reg + EXP_W'(hi);
                end
                done_next  = 1'b1;
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg <= exp_next;
        man_reg <= man_next;
        am_reg  <= am_next;
        bm_reg  <= bm_next;
        acc_reg <= acc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.val.exp = exp_reg;
    assign rsp.val.man = man_reg;

endmodule

@@ rtl/core/d2d_digit_ram.sv @@
// Digit store, one write and one registered read port.
module d2d_digit_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [3:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [3:0]    rdata
);

    logic [3:0] mem [DEPTH];
    logic [3:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/double_to_decimal_digits_unit.sv @@
// Channel | Dir | Payload                                       | Transaction
// item    | in  | value_bits, fixed_mode, digits_requested      | one conversion
// result  | out | digit, digit_valid, point_position, negative, | one digit of the
//         |     | special, last                                 | run
//
// Steps: a multiply in the shared unit runs four partial-product steps, a
// rounding step and the handshake; a normalize shifts 16 or 1 bit at a time.
// Scaling does one compare per table step plus up to about ten multiplies.
// Each digit up to PRECISION+2 significant digits takes a normalize plus a
// multiply by ten; a zero digit takes the multiply only (none once v is
// exactly zero), and digits past that limit are written as zero directly.
// A rounding carry ripples one digit at a time; then each digit goes out
// through a registered digit store read, plus any result stalls.
// Rate is set by the one shared multiply/normalize unit.
// Reset clears all control state; no clearing pass on the digit store.
// item.ready is high only while idle; result stalls simply hold the digit.
module double_to_decimal_digits_unit
    import d2d_pkg::*;
#(
    parameter int MAX_DIGITS = 30,
    parameter int PRECISION  = 15
) (
    input  logic      clk,
    input  logic      rst_n,
    d2d_in_if.sink    item,
    d2d_out_if.source result
);

    localparam int BUF_DEPTH = MAX_DIGITS + 2;
    localparam int CNT_W     = $clog2(MAX_DIGITS + 2);
    localparam int SC_W      = $clog2(PRECISION + 3);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_NEG, S_NEG_WAIT, S_POS, S_POS_WAIT, S_DIG,
        S_DNORM_WAIT, S_DMUL, S_DMUL_WAIT, S_RND, S_RND_CHK, S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    state_t            state_reg, state_next;
    d2d_fp_t           v_reg, v_next;
    logic              vzero_reg, vzero_next;
    logic signed [9:0] pc_reg, pc_next;       // decimal point position
    logic [CNT_W-1:0]  nd_reg, nd_next;       // digits in the run
    logic [CNT_W-1:0]  k_reg, k_next;         // digit index
    logic [3:0]        i_reg, i_next;         // power table index
    logic              sig_reg, sig_next;
    logic [SC_W-1:0]   sc_reg, sc_next;       // significant digit count
    logic              fixed_reg, fixed_next;
    logic              neg_reg, neg_next;
    logic              special_reg, special_next;
    logic              zin_reg, zin_next;
    logic [3:0]        lastc_reg, lastc_next; // rounding digit

    d2d_fpu_req_t      fpu_req;
    d2d_fpu_rsp_t      fpu_rsp;

    logic              ram_we, ram_re;
    logic [CNT_W-1:0]  ram_waddr, ram_raddr;
    logic [3:0]        ram_wdata, ram_rdata;

    // input decode
    logic [10:0]       in_exp;
    logic [6:0]        req_sat;
    logic [CNT_W-1:0]  nd_req;

    // digit extraction from v in [0,16)
    logic [MAN_W+2:0]  v_sh;
    logic [3:0]        ip;
    logic [3:0]        cdig;
    logic [MAN_W+2:0]  frac_x;
    logic [10:0]       fix_sum;
    logic              run_empty;

    d2d_fp_t           one_c, ten_c;

    assign one_c = unpack_normal(neg_pow_bits(4'd9));
    assign ten_c = unpack_normal(pos_pow_bits(4'd8));

    assign in_exp  = item.value_bits[62:52];
    assign req_sat = (7'(item.digits_requested) > 7'(MAX_DIGITS))
                     ? 7'(MAX_DIGITS) : 7'(item.digits_requested);
    assign nd_req  = req_sat[CNT_W-1:0];

    assign v_sh    = {3'b000, v_reg.man} << v_reg.exp[1:0];
    assign ip      = v_sh[MAN_W+2:MAN_W-1];
    assign cdig    = (ip > DIGIT_MAX) ? DIGIT_MAX : ip;
    // exact: v - c never needs more than 53 bits
    assign frac_x  = v_sh - ((MAN_W+3)'(cdig) << (MAN_W - 1));
    assign fix_sum = 11'(nd_reg) + 11'(pc_reg[8:0]);

    assign run_empty = special_reg || (nd_reg == '0);

    always_comb
    begin
        state_next   = state_reg;
        v_next       = v_reg;
        vzero_next   = vzero_reg;
        pc_next      = pc_reg;
        nd_next      = nd_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        sig_next     = sig_reg;
        sc_next      = sc_reg;
        fixed_next   = fixed_reg;
        neg_next     = neg_reg;
        special_next = special_reg;
        zin_next     = zin_reg;
        lastc_next   = lastc_reg;

        fpu_req       = '0;
        ram_we        = 1'b0;
        ram_waddr     = k_reg;
        ram_wdata     = 4'd0;
        ram_re        = 1'b0;
        ram_raddr     = k_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    nd_next      = nd_req;
                    fixed_next   = item.fixed_mode;
                    neg_next     = item.value_bits[63];
                    special_next = (in_exp == 11'h7FF);
                    zin_next     = (item.value_bits[62:0] == '0);
                    vzero_next   = 1'b0;
                    pc_next      = 10'sd1;
                    i_next       = 4'd0;
                    k_next       = '0;
                    if ((in_exp == 11'h7FF) || (item.value_bits[62:0] == '0))
                    begin
                        pc_next    = 10'sd0;
                        state_next = S_EMIT_RD;
                    end
                    else if (in_exp == '0)
                    begin
                        // subnormal: normalize first
                        fpu_req.start = 1'b1;
                        fpu_req.mul   = 1'b0;
                        fpu_req.a.exp = -13'sd1022;
                        fpu_req.a.man = {1'b0, item.value_bits[51:0]};
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        v_next     = unpack_normal(item.value_bits);
                        state_next = S_NEG;
                    end
                end
            end
            S_LOAD:
            begin
                if (fpu_rsp.done)
                begin
                    v_next     = fpu_rsp.val;
                    state_next = S_NEG;
                end
            end
            S_NEG:
            begin
                if ((i_reg == 4'(POW_STEPS)) || !fp_lt(v_reg, one_c))
                begin
                    i_next     = 4'd0;
                    state_next = S_POS;
                end
                else if (fp_lt(v_reg, unpack_normal(neg_pow_bits(i_reg + 4'd1))))
                begin
                    fpu_req.start = 1'b1;
                    fpu_req.mul   = 1'b1;
                    fpu_req.a     = v_reg;
                    fpu_req.b     = unpack_normal(pos_pow_bits(i_reg));
                    pc_next       = pc_reg - 10'(POW_START >> i_reg);
                    state_next    = S_NEG_WAIT;
                end
                else
                    i_next = i_reg + 4'd1;
            end
            S_NEG_WAIT:
            begin
                if (fpu_rsp.done)
                begin
                    v_next     = fpu_rsp.val;
                    state_next = S_NEG;
                end
            end
            S_POS:
            begin
                if ((i_reg == 4'(POW_STEPS)) || fp_lt(v_reg, ten_c))
                begin
                    if (fixed_reg && (pc_reg > 10'sd0))
                        nd_next = (fix_sum > 11'(MAX_DIGITS))
                                  ? CNT_W'(MAX_DIGITS) : fix_sum[CNT_W-1:0];
                    k_next     = '0;
                    sc_next    = '0;
                    sig_next   = 1'b0;
                    state_next = S_DIG;
                end
                else if (!fp_lt(v_reg, unpack_normal(pos_pow_bits(i_reg))))
                begin
                    fpu_req.start = 1'b1;
                    fpu_req.mul   = 1'b1;
                    fpu_req.a     = v_reg;
                    fpu_req.b     = unpack_normal(neg_pow_bits(i_reg));
                    pc_next       = pc_reg + 10'(POW_START >> i_reg);
                    state_next    = S_POS_WAIT;
                end
                else
                    i_next = i_reg + 4'd1;
            end
            S_POS_WAIT:
            begin
                if (fpu_rsp.done)
                begin
                    v_next     = fpu_rsp.val;
                    state_next = S_POS;
                end
            end
            S_DIG:
            begin
                if (k_reg > nd_reg)
                begin
                    if (lastc_reg >= ROUND_UP)
                    begin
                        k_next     = nd_reg;
                        state_next = S_RND;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = S_EMIT_RD;
                    end
                end
                else if (sc_reg > SC_W'(PRECISION + 1))
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = 4'd0;
                    lastc_next = 4'd0;
                    k_next     = k_reg + CNT_W'(1);
                end
                else if (vzero_reg || v_reg.exp[EXP_W-1])
                begin
                    // digit is zero; v - 0 = v
                    ram_we     = 1'b1;
                    ram_wdata  = 4'd0;
                    lastc_next = 4'd0;
                    sc_next    = sc_reg + SC_W'(sig_reg);
                    k_next     = k_reg + CNT_W'(1);
                    if (!vzero_reg)
                    begin
                        fpu_req.start = 1'b1;
                        fpu_req.mul   = 1'b1;
                        fpu_req.a     = v_reg;
                        fpu_req.b     = ten_c;
                        state_next    = S_DMUL_WAIT;
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = cdig;
                    lastc_next = cdig;
                    sig_next   = sig_reg | (cdig != 4'd0);
                    sc_next    = sc_reg + SC_W'(sig_reg | (cdig != 4'd0));
                    k_next     = k_reg + CNT_W'(1);
                    if (frac_x == '0)
                        vzero_next = 1'b1;
                    else
                    begin
                        fpu_req.start = 1'b1;
                        fpu_req.mul   = 1'b0;
                        fpu_req.a.exp = '0;
                        fpu_req.a.man = frac_x[MAN_W-1:0];
                        state_next    = S_DNORM_WAIT;
                    end
                end
            end
            S_DNORM_WAIT:
            begin
                if (fpu_rsp.done)
                begin
                    v_next     = fpu_rsp.val;
                    state_next = S_DMUL;
                end
            end
            S_DMUL:
            begin
                fpu_req.start = 1'b1;
                fpu_req.mul   = 1'b1;
                fpu_req.a     = v_reg;
                fpu_req.b     = ten_c;
                state_next    = S_DMUL_WAIT;
            end
            S_DMUL_WAIT:
            begin
                if (fpu_rsp.done)
                begin
                    v_next     = fpu_rsp.val;
                    state_next = S_DIG;
                end
            end
            S_RND:
            begin
                if (k_reg == '0)
                begin
                    // carry out of the first digit: 1000...
                    ram_we     = 1'b1;
                    ram_wdata  = 4'd1;
                    pc_next    = pc_reg + 10'sd1;
                    nd_next    = nd_reg + CNT_W'(fixed_reg);
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = 4'd0;
                    ram_re     = 1'b1;
                    ram_raddr  = k_reg - CNT_W'(1);
                    k_next     = k_reg - CNT_W'(1);
                    state_next = S_RND_CHK;
                end
            end
            S_RND_CHK:
            begin
                if (ram_rdata != DIGIT_MAX)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata + 4'd1;
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else
                    state_next = S_RND;
            end
            S_EMIT_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_EMIT_OUT;
            end
            default:
            begin
                if (result.ready)
                begin
                    if (run_empty || (k_reg == nd_reg - CNT_W'(1)))
                        state_next = S_IDLE;
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vzero_reg   <= 1'b0;
            pc_reg      <= '0;
            nd_reg      <= '0;
            k_reg       <= '0;
            i_reg       <= '0;
            sig_reg     <= 1'b0;
            sc_reg      <= '0;
            fixed_reg   <= 1'b0;
            neg_reg     <= 1'b0;
            special_reg <= 1'b0;
            zin_reg     <= 1'b0;
            lastc_reg   <= '0;
            v_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            vzero_reg   <= vzero_next;
            pc_reg      <= pc_next;
            nd_reg      <= nd_next;
            k_reg       <= k_next;
            i_reg       <= i_next;
            sig_reg     <= sig_next;
            sc_reg      <= sc_next;
            fixed_reg   <= fixed_next;
            neg_reg     <= neg_next;
            special_reg <= special_next;
            zin_reg     <= zin_next;
            lastc_reg   <= lastc_next;
            v_reg       <= v_next;
        end
    end

    d2d_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .rsp   (fpu_rsp)
    );

    d2d_digit_ram #(
        .DEPTH (BUF_DEPTH),
        .AW    (CNT_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign item.ready = (state_reg == S_IDLE);

    assign result.valid          = (state_reg == S_EMIT_OUT);
    assign result.digit          = (run_empty || zin_reg) ? 4'd0 : ram_rdata;
    assign result.digit_valid    = !run_empty;
    assign result.point_position = pc_reg;
    assign result.negative       = neg_reg;
    assign result.special        = special_reg;
    assign result.last           = run_empty || (k_reg == nd_reg - CNT_W'(1));

endmodule

@@ rtl/core/d2d_checker.sv @@
module d2d_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] digit,
    input logic       digit_valid,
    input logic       special,
    input logic       last
);

    // one conversion at a time
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is offered");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready right after an accepted transaction");

    a_special_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && special) |-> (last && !digit_valid && digit == 4'd0))
        else $error("special result is not a single empty transaction");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && digit_valid) |-> (digit <= 4'd9))
        else $error("digit out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(digit)
                                       && $stable(last)))
        else $error("stalled result changed");

endmodule

bind double_to_decimal_digits_unit d2d_checker u_d2d_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (item.valid),
    .in_ready    (item.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .digit       (result.digit),
    .digit_valid (result.digit_valid),
    .special     (result.special),
    .last        (result.last)
);

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import d2d_pkg::*;

    localparam int MAX_DIGITS   = 30;
    localparam int PRECISION    = 15;
    localparam int RANDOM_ITEMS = 180;
    // idle cycles on both channels before the run is declared hung
    localparam int HANG_LIMIT   = 20000;
    localparam int LONG_HOLD    = 3000;
    // tail after the last digit
    localparam int TAIL_CYCLES  = 400;

    // one digit transaction on the result channel
    typedef struct {
        logic [3:0]        digit;
        logic              digit_valid;
        logic signed [9:0] point_position;
        logic              negative;
        logic              special;
        logic              last;
    } digit_result_t;

    // 1e-256 .. 1e-1, 1 and 1e256 .. 1e1 as binary64 patterns
    localparam logic [63:0] NEG_SCALE [10] = '{
        64'h0ac8062864ac6f43, 64'h255bba08cf8c979d, 64'h32a50ffd44f4a73d,
        64'h3949f623d5a8a733, 64'h3c9cd2b297d889bc, 64'h3e45798ee2308c3a,
        64'h3f1a36e2eb1c432d, 64'h3f847ae147ae147b, 64'h3fb999999999999a,
        64'h3ff0000000000000
    };
    localparam logic [63:0] POS_SCALE [9] = '{
        64'h75154fdd7f73bf3c, 64'h5a827748f9301d32, 64'h4d384f03e93ff9f5,
        64'h4693b8b5b5056e17, 64'h4341c37937e08000, 64'h4197d78400000000,
        64'h40c3880000000000, 64'h4059000000000000, 64'h4024000000000000
    };

    logic clk;
    logic rst_n;

    d2d_in_if  item_if();
    d2d_out_if result_if();

    double_to_decimal_digits_unit #(
        .MAX_DIGITS(MAX_DIGITS),
        .PRECISION (PRECISION)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_if.sink),
        .result(result_if.source)
    );

    digit_result_t pending_digits[$];
    int  error_count;
    int  burst_left;
    bit  long_hold_req;

    // digit store of the predictor; two extra slots for the rounding digit and the fixed-mode carry
    logic [3:0] digit_store [MAX_DIGITS + 2];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    // Predict the digit run of one conversion and queue it.
    function automatic void predict_digit_run(input logic [63:0] bits,
                                              input logic fixed,
                                              input logic [5:0] requested);
        digit_result_t r;
        int  count;
        int  point;
        int  pw;
        int  i;
        int  k;
        int  sig_seen;
        int  sig_count;
        int  c;
        real v;
        logic [62:0] mag;

        count = (requested > MAX_DIGITS) ? MAX_DIGITS : requested;
        mag   = bits[62:0];
        r.negative = bits[63];
        r.special  = 1'b0;

        // NaN and infinity: single flagged transaction, no digits
        if (mag[62:52] == 11'h7ff)
        begin
            r.digit = 4'd0;
            r.digit_valid = 1'b0;
            r.point_position = '0;
            r.special = 1'b1;
            r.last = 1'b1;
            pending_digits.push_back(r);
            return;
        end

        if (mag == '0)
        begin
            for (k = 0; k < count; k++)
                digit_store[k] = 4'd0;
            point = 0;
        end
        else
        begin
            v = $bitstoreal({1'b0, mag});
            point = 1;
            pw = 256;
            i = 0;
            // scale up into [1, 10)
            while (v < 1.0 && i < 9)
            begin
                while (v < $bitstoreal(NEG_SCALE[i + 1]))
                begin
                    v = v * $bitstoreal(POS_SCALE[i]);
                    point -= pw;
                end
                pw = pw >> 1;
                i++;
            end
            pw = 256;
            i = 0;
            // scale down into [1, 10)
            while (v >= 10.0 && i < 9)
            begin
                while (v >= $bitstoreal(POS_SCALE[i]))
                begin
                    v = v * $bitstoreal(NEG_SCALE[i]);
                    point += pw;
                end
                pw = pw >> 1;
                i++;
            end

            if (fixed && point > 0)
                count = (count + point > MAX_DIGITS) ? MAX_DIGITS : count + point;

            // one digit per multiply by ten, plus the rounding digit
            sig_seen = 0;
            sig_count = 0;
            c = 0;
            for (k = 0; k <= count; k++)
            begin
                if (sig_count > PRECISION + 1)
                    c = 0;
                else
                begin
                    c = (v >= 10.0) ? 9 : $rtoi(v);
                    v = (v - real'(c)) * 10.0;
                    if (c != 0)
                        sig_seen = 1;
                    sig_count += sig_seen;
                end
                digit_store[k] = c[3:0];
            end

            // round half up, ripple the carry toward the first digit
            if (c >= 5)
            begin
                k = count;
                forever
                begin
                    if (k == 0)
                    begin
                        count += fixed;
                        point++;
                        digit_store[0] = 4'd1;
                        break;
                    end
                    digit_store[k] = 4'd0;
                    k--;
                    if (digit_store[k] != 4'd9)
                    begin
                        digit_store[k] = digit_store[k] + 4'd1;
                        break;
                    end
                end
            end
        end

        r.point_position = point[9:0];
        if (count == 0)
        begin
            r.digit = 4'd0;
            r.digit_valid = 1'b0;
            r.last = 1'b1;
            pending_digits.push_back(r);
            return;
        end
        for (k = 0; k < count; k++)
        begin
            r.digit = digit_store[k];
            r.digit_valid = 1'b1;
            r.last = (k + 1 == count);
            pending_digits.push_back(r);
        end
    endfunction

    // Offer one conversion and hold it until accepted; the sender runs in
    // bursts, so after some transactions it drops valid for a random gap.
    task automatic send_conversion(input logic [63:0] bits, input logic fixed,
                                   input logic [5:0] requested);
        int gap;
        item_if.valid            <= 1'b1;
        item_if.value_bits       <= bits;
        item_if.fixed_mode       <= fixed;
        item_if.digits_requested <= requested;
        do
            @(posedge clk);
        while (!item_if.ready);
        predict_digit_run(bits, fixed, requested);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 6);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic end_of_stream();
        item_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_drain();
        while (pending_digits.size() != 0)
            @(posedge clk);
    endtask

    // Random binary64 pattern spread over all exponents, with extra weight on
    // denormals, short integers and values just under a decade boundary.
    function automatic logic [63:0] random_value();
        logic [63:0] b;
        logic [63:0] int_bits;
        int kind;
        kind = $urandom_range(0, 19);
        b = {$urandom(), $urandom()};
        case (kind)
            0:       b[62:52] = 11'h000;                          // denormal
            1:       b[62:52] = 11'h7ff;                          // NaN / inf
            2:
            begin
                int_bits = $realtobits(real'($urandom_range(1, 99999)));
                b = {b[63], int_bits[62:0]};
            end
            3:       b = {b[63], 11'h3fe, 4'hf, b[47:0] | 48'hfff0_0000_0000};
            4:       b[62:52] = 11'h000 | (b[62:52] & 11'h00f);   // very small
            5:       b[62:52] = 11'h7f0 | (b[62:52] & 11'h00e);   // very large
            6:       b = {b[63], 63'd0};                          // zero
            7, 8:    b[62:52] = 11'h3f0 + (b[62:52] & 11'h01f);   // near one
            default: ;
        endcase
        return b;
    endfunction

    function automatic logic [5:0] random_count();
        return ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 12));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and each named corner of the conversion.
    task automatic test_directed_values();
        send_conversion(64'h0000000000000000, 1'b0, 6'd5);   // zero
        send_conversion(64'h8000000000000000, 1'b1, 6'd3);   // negative zero, fixed
        send_conversion(64'h0000000000000000, 1'b0, 6'd0);   // zero, empty run
        send_conversion(64'h7ff0000000000000, 1'b0, 6'd10);  // +inf
        send_conversion(64'hfff0000000000000, 1'b1, 6'd10);  // -inf
        send_conversion(64'h7fffffffffffffff, 1'b0, 6'd63);  // NaN, all ones
        send_conversion(64'h3ff0000000000000, 1'b0, 6'd0);   // 1.0, empty run
        send_conversion(64'h3ff0000000000000, 1'b0, 6'd63);  // saturated count
        send_conversion(64'h0000000000000001, 1'b0, 6'd20);  // min denormal
        send_conversion(64'h000fffffffffffff, 1'b1, 6'd30);  // max denormal
        send_conversion(64'h0010000000000000, 1'b0, 6'd17);  // min normal
        send_conversion(64'h7fefffffffffffff, 1'b1, 6'd63);  // max double, fixed cap
        send_conversion(64'hffefffffffffffff, 1'b0, 6'd1);
        send_conversion(64'h3feffffffffffffe, 1'b0, 6'd4);   // carry out of first digit
        send_conversion(64'h3fee666666666666, 1'b1, 6'd0);   // 0.95 fixed: carry grows run
        send_conversion(64'h4023fffffffffff0, 1'b1, 6'd30);  // just under 10, fixed, max
        send_conversion(64'h4059000000000000, 1'b1, 6'd2);   // 100 fixed
        send_conversion(64'h3fb999999999999a, 1'b0, 6'd30);  // 0.1, past precision
        send_conversion(64'h3fe0000000000000, 1'b0, 6'd1);   // 0.5, one digit
        send_conversion(64'h4415af1d78b58c40, 1'b1, 6'd25);  // 1e20 fixed
        send_conversion(64'hc00921fb54442d18, 1'b0, 6'd16);  // -pi
        end_of_stream();
    endtask

    task automatic test_random_conversions();
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_conversion(random_value(), 1'($urandom_range(0, 1)), random_count());
        end_of_stream();
    endtask

    // Receiver holds off for a long stretch while items keep coming; the
    // block fills with one conversion and must stall its input.
    task automatic test_output_backpressure();
        long_hold_req = 1'b1;
        for (int n = 0; n < 6; n++)
            send_conversion(random_value(), 1'($urandom_range(0, 1)), 6'd30);
        end_of_stream();
    endtask

    // Sender stops until every digit is out, then restarts from idle.
    task automatic test_drain_pause();
        wait_for_drain();
        for (int n = 0; n < 4; n++)
            send_conversion(random_value(), 1'b0, random_count());
        end_of_stream();
    endtask

    // ------------------------------------------------------------------
    // Receiver: windows of always-ready and random stalls, plus the long
    // hold-off when a test asks for it.
    // ------------------------------------------------------------------
    initial
    begin
        int window;
        int stall_pct;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                result_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end
            window = $urandom_range(8, 80);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
            repeat (window)
            begin
                result_if.ready <= ($urandom_range(1, 100) > stall_pct);
                @(posedge clk);
            end
        end
    end

    // Checker: each digit transaction against the oldest expectation.
    always @(posedge clk)
    begin
        digit_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_digits.size() == 0)
            begin
                $error("unexpected digit transaction: digit %0d last %0b",
                       result_if.digit, result_if.last);
                error_count++;
            end
            else
            begin
                want = pending_digits.pop_front();
                if (result_if.digit !== want.digit)
                begin
                    $error("digit: expected %0d, got %0d", want.digit, result_if.digit);
                    error_count++;
                end
                if (result_if.digit_valid !== want.digit_valid)
                begin
                    $error("digit_valid: expected %0b, got %0b",
                           want.digit_valid, result_if.digit_valid);
                    error_count++;
                end
                if (result_if.point_position !== want.point_position)
                begin
                    $error("point_position: expected %0d, got %0d",
                           want.point_position, result_if.point_position);
                    error_count++;
                end
                if (result_if.negative !== want.negative)
                begin
                    $error("negative: expected %0b, got %0b",
                           want.negative, result_if.negative);
                    error_count++;
                end
                if (result_if.special !== want.special)
                begin
                    $error("special: expected %0b, got %0b",
                           want.special, result_if.special);
                    error_count++;
                end
                if (result_if.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, result_if.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: consecutive cycles with no transaction on either channel.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= HANG_LIMIT)
            begin
                $display("double_to_decimal_digits_unit verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        error_count   = 0;
        burst_left    = 0;
        long_hold_req = 1'b0;
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.value_bits = '0;
        item_if.fixed_mode = 1'b0;
        item_if.digits_requested = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        test_random_conversions();
        test_output_backpressure();
        test_drain_pause();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_digits.size() == 0)
            $display("double_to_decimal_digits_unit verification clean");
        else
            $display("double_to_decimal_digits_unit verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/d2d_pkg.sv
rtl/core/d2d_in_if.sv
rtl/core/d2d_out_if.sv
rtl/core/d2d_fpu.sv
rtl/core/d2d_digit_ram.sv
rtl/core/double_to_decimal_digits_unit.sv
rtl/core/d2d_checker.sv
tb/tb.sv
